[rtl/ceg_pkg.sv]
package ceg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 24;
    localparam int MANT_FRAC = 30;
    localparam int DIV_STEPS = 34;

    localparam logic [16:0] ONE_FX       = 17'h10000;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [19:0] LOSS_MAX     = 20'hFFFFF;
    localparam logic [33:0] GRAD_MAG_MAX = 34'h080000000;
    localparam logic [29:0] TOTAL_MAX    = 30'h3FFFFFFF;

    typedef struct packed {
        logic [16:0] p;
        logic [16:0] d;
        logic        last;
        logic        zero;
        logic [4:0]  e;
        logic [30:0] m;
    } ceg_item_t;

endpackage

[rtl/ceg_front.sv]
module ceg_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [16:0]         predicted,
    input  logic [16:0]         target,
    input  logic                last_element,
    output logic                q_valid,
    input  logic                q_pop,
    output ceg_pkg::ceg_item_t  q_item
);

    ceg_pkg::ceg_item_t item;
    ceg_pkg::ceg_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    // clamp, zero check and normalize
    always_comb begin
        item.p    = (predicted > ceg_pkg::ONE_FX) ? ceg_pkg::ONE_FX : predicted;
        item.d    = (target > ceg_pkg::ONE_FX) ? ceg_pkg::ONE_FX : target;
        item.last = last_element;
        item.zero = (item.p == 17'd0);
        item.e    = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (item.p[i]) begin
                item.e = 5'(i);
            end
        end
        item.m = 31'(item.p) << (5'd30 - item.e);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[rtl/ceg_back.sv]
module ceg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  ceg_pkg::ceg_item_t  q_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [19:0]         element_loss,
    output logic [31:0]         element_gradient,
    output logic [29:0]         loss_total,
    output logic                is_last,
    output logic                domain_error
);

    typedef enum logic [2:0] {S_IDLE, S_ITER, S_MUL1, S_MUL2, S_DONE} state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] m_reg;
    logic [23:0] f_reg;
    logic [4:0]  e_reg;
    logic [16:0] p_reg, d_reg;
    logic        last_reg, zero_reg;
    logic [33:0] n_reg, q_reg;
    logic [16:0] rem_reg;
    logic [28:0] t_reg;
    logic [19:0] loss_reg;
    logic [29:0] acc_reg;
    logic        out_valid_reg;

    logic [61:0] sq;
    logic [31:0] m2;
    logic [17:0] rem_sh;
    logic        ge;
    logic [28:0] l_val;
    logic [60:0] tprod;
    logic [45:0] lprod;
    logic [21:0] loss_full;
    logic [33:0] mag;
    logic [30:0] tot_sum;
    logic [29:0] tot;
    logic        load_out;

    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign m2     = sq[61:30];
    assign rem_sh = {rem_reg, n_reg[33]};
    assign ge     = (rem_sh >= {1'b0, p_reg});
    assign l_val  = {5'd16 - e_reg, 24'd0} - 29'(f_reg);
    assign tprod  = 61'(l_val) * 61'(ceg_pkg::LN2_Q32);
    assign lprod  = 46'(d_reg) * 46'(t_reg);
    assign loss_full = 22'((lprod + 46'h800000) >> 24);
    assign mag    = (q_reg > ceg_pkg::GRAD_MAG_MAX) ? ceg_pkg::GRAD_MAG_MAX : q_reg;
    assign tot_sum = 31'(acc_reg) + 31'(loss_reg);
    assign tot    = tot_sum[30] ? ceg_pkg::TOTAL_MAX : tot_sum[29:0];

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= 30'd0;
            cnt_reg       <= 6'd0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        p_reg    <= q_item.p;
                        d_reg    <= q_item.d;
                        last_reg <= q_item.last;
                        zero_reg <= q_item.zero;
                        e_reg    <= q_item.e;
                        m_reg    <= q_item.m;
                        f_reg    <= 24'd0;
                        rem_reg  <= 17'd0;
                        n_reg    <= (34'(q_item.d) << ceg_pkg::FRAC_BITS)
                                    + 34'(q_item.p[16:1]);
                        cnt_reg  <= 6'd0;
                        if (q_item.zero) begin
                            loss_reg <= ceg_pkg::LOSS_MAX;
                            q_reg    <= ceg_pkg::GRAD_MAG_MAX;
                            state_reg <= S_DONE;
                        end else begin
                            q_reg    <= 34'd0;
                            state_reg <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    if (cnt_reg < 6'(ceg_pkg::LOG_FRAC)) begin
                        f_reg <= {f_reg[22:0], m2[31]};
                        m_reg <= m2[31] ? m2[31:1] : m2[30:0];
                    end
                    rem_reg <= ge ? 17'(rem_sh - {1'b0, p_reg}) : rem_sh[16:0];
                    q_reg   <= {q_reg[32:0], ge};
                    n_reg   <= {n_reg[32:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(ceg_pkg::DIV_STEPS - 1)) begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    t_reg     <= tprod[60:32];
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    loss_reg  <= (loss_full > 22'(ceg_pkg::LOSS_MAX)) ?
                                 ceg_pkg::LOSS_MAX : loss_full[19:0];
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        element_loss     <= loss_reg;
                        element_gradient <= 32'(34'd0 - mag);
                        loss_total       <= tot;
                        is_last          <= last_reg;
                        domain_error     <= zero_reg;
                        acc_reg          <= last_reg ? 30'd0 : tot;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/cross_entropy_loss_grad.sv]
// channel | direction | fields
// s_      | in        | predicted, target, last_element
// m_      | out       | element_loss, element_gradient, loss_total, is_last, domain_error
//
// the back end loads an element, runs 34 divide steps (the first LOG_FRAC of them also do the log),
// then the multiply states S_MUL1 and S_MUL2 and write-out; a zero probability goes straight to write-out
// a two-word queue lets the front keep accepting while the back end works
// aresetn is synchronous; it empties the queue and clears the running sum
// the output register holds its word until m_ready; the back end waits there
module cross_entropy_loss_grad (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [16:0]        s_predicted,
    input  logic [16:0]        s_target,
    input  logic               s_last_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [19:0]        m_element_loss,
    output logic signed [31:0] m_element_gradient,
    output logic [29:0]        m_loss_total,
    output logic               m_is_last,
    output logic               m_domain_error
);

    logic               q_valid, q_pop;
    ceg_pkg::ceg_item_t q_item;

    ceg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .predicted    (s_predicted),
        .target       (s_target),
        .last_element (s_last_element),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item)
    );

    ceg_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_item           (q_item),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .element_loss     (m_element_loss),
        .element_gradient (m_element_gradient),
        .loss_total       (m_loss_total),
        .is_last          (m_is_last),
        .domain_error     (m_domain_error)
    );

endmodule

[tb/sv/cross_entropy_loss_grad_tb.sv]
`timescale 1ns / 100ps

module cross_entropy_loss_grad_tb;

    localparam logic [63:0] LN2_FX       = 64'd2977044472;
    localparam logic [63:0] ONE_P        = 64'd65536;
    localparam logic [63:0] LOSS_SAT     = 64'hFFFFF;
    localparam logic [63:0] GRAD_MAG_SAT = 64'h80000000;
    localparam logic [63:0] SUM_SAT      = 64'h3FFFFFFF;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [19:0] loss;
        logic [31:0] grad;
        logic [29:0] total;
        logic        last;
        logic        dom;
    } loss_word_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [16:0]        s_predicted;
    logic [16:0]        s_target;
    logic               s_last_element;
    logic               m_valid;
    logic               m_ready;
    logic [19:0]        m_element_loss;
    logic signed [31:0] m_element_gradient;
    logic [29:0]        m_loss_total;
    logic               m_is_last;
    logic               m_domain_error;

    loss_word_t  expected_words[$];
    logic [63:0] running_model;
    int          errors;
    int          cycles;
    int          results_seen;
    int          items_sent;
    bit          idle_on;
    bit          hold_sink;

    cross_entropy_loss_grad u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_predicted       (s_predicted),
        .s_target          (s_target),
        .s_last_element    (s_last_element),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_element_loss    (m_element_loss),
        .m_element_gradient(m_element_gradient),
        .m_loss_total      (m_loss_total),
        .m_is_last         (m_is_last),
        .m_domain_error    (m_domain_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // -log2(p) in q.24 by repeated squaring of the mantissa
    function automatic logic [63:0] neg_log2(input logic [63:0] p);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb = 0;
        frac = 0;
        for (int i = 0; i <= 16; i++) begin
            if (p[i]) msb = i;
        end
        m = p << (30 - msb);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(16 - msb) << 24) - frac;
    endfunction

    function automatic loss_word_t predict_loss(input logic [16:0] pin, input logic [16:0] din,
                                                input logic lastin);
        loss_word_t  w;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] loss;
        logic [63:0] mag;
        logic [63:0] sum;
        p = (pin > ONE_P) ? ONE_P : 64'(pin);
        d = (din > ONE_P) ? ONE_P : 64'(din);
        w.dom = (p == 0);
        if (p == 0) begin
            loss = LOSS_SAT;
            mag = GRAD_MAG_SAT;
        end else begin
            t = (neg_log2(p) * LN2_FX) >> 32;
            loss = (d * t + (64'd1 << 23)) >> 24;
            if (loss > LOSS_SAT) loss = LOSS_SAT;
            mag = ((d << 16) + (p >> 1)) / p;
            if (mag > GRAD_MAG_SAT) mag = GRAD_MAG_SAT;
        end
        sum = running_model + loss;
        if (sum > SUM_SAT) sum = SUM_SAT;
        running_model = lastin ? 64'd0 : sum;
        w.loss = loss[19:0];
        w.grad = 32'(64'd0 - mag);
        w.total = sum[29:0];
        w.last = lastin;
        return w;
    endfunction

    task automatic send_word(input logic [16:0] p, input logic [16:0] d, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_predicted    <= p;
        s_target       <= d;
        s_last_element <= last;
        expected_words.insert(expected_words.size(), predict_loss(p, d, last));
        items_sent++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [16:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'h10000;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(1, 64));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_directed();
        send_word(17'd0, 17'h10000, 1'b0);
        send_word(17'd0, 17'd0, 1'b0);
        send_word(17'h1FFFF, 17'h1FFFF, 1'b0);
        send_word(17'h10000, 17'h10000, 1'b1);
        send_word(17'd1, 17'h10000, 1'b0);
        send_word(17'd1, 17'd1, 1'b0);
        send_word(17'd2, 17'hFFFF, 1'b0);
        send_word(17'h8000, 17'h10000, 1'b0);
        send_word(17'hFFFF, 17'h0FFFF, 1'b0);
        send_word(17'h5555, 17'h0AAAA, 1'b1);
        send_word(17'h1, 17'h1FFFF, 1'b0);
        send_word(17'h3, 17'h2, 1'b1);
        drain_results();
    endtask

    task automatic test_sink_hold();
        hold_sink = 1'b1;
        for (int i = 0; i < 8; i++) send_word(rand_operand(), rand_operand(), 1'b0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(rand_operand(), rand_operand(), $urandom_range(0, 15) == 0);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_predicted = '0;
        s_target = '0;
        s_last_element = 1'b0;
        running_model = 0;
        errors = 0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_sink = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_sink_hold();
        test_random(300);
        drain_results();
        test_random(250);
        idle_on = 1'b0;
        test_random(150);
        drain_results();
        repeat (100) @(posedge aclk);
        $display("sent %0d words, checked %0d results (zero p, clamping, gradient limit, stalls)",
                 items_sent, results_seen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // sink side: random stalls, one long hold-off when asked
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        loss_word_t w;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                w = expected_words.pop_front();
                if (m_element_loss !== w.loss) begin
                    $error("element_loss exp %h got %h", w.loss, m_element_loss);
                    errors++;
                end
                if (m_element_gradient !== w.grad) begin
                    $error("element_gradient exp %h got %h", w.grad, m_element_gradient);
                    errors++;
                end
                if (m_loss_total !== w.total) begin
                    $error("loss_total exp %h got %h", w.total, m_loss_total);
                    errors++;
                end
                if (m_is_last !== w.last) begin
                    $error("is_last exp %b got %b", w.last, m_is_last);
                    errors++;
                end
                if (m_domain_error !== w.dom) begin
                    $error("domain_error exp %b got %b", w.dom, m_domain_error);
                    errors++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        results_seen = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
rtl/ceg_pkg.sv
rtl/ceg_front.sv
rtl/ceg_back.sv
rtl/cross_entropy_loss_grad.sv
tb/sv/cross_entropy_loss_grad_tb.sv
